// ===== hw/rtl/fifo_with_running_max_top_defines.svh =====
// Assertion macros shared by the checker of the running-max FIFO.
// No dependencies; clk and rst must be visible where a macro is used.
`ifndef FIFO_WITH_RUNNING_MAX_TOP_DEFINES_SVH
`define FIFO_WITH_RUNNING_MAX_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FWM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("running-max FIFO check failed");

// Next-cycle implication, disabled during reset.
`define FWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("running-max FIFO check failed");

`endif

// ===== hw/rtl/fwm_pkg.sv =====
// Package of the running-max FIFO: status codes, controller states and
// the command and status structs between controller and datapath. No dependencies.
package fwm_pkg;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_ENQ_SCAN = 5'b00010,
    S_DEQ_POP  = 5'b00100,
    S_DEQ_MAX  = 5'b01000,
    S_FIN      = 5'b10000
  } state_t;

  typedef struct packed {
    logic    load;
    status_t status;
    logic    entry_push;
    logic    entry_pop;
    logic    cand_drop_back;
    logic    cand_append;
    logic    cand_drop_front;
    logic    load_max;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic op_deq;
    logic full;
    logic empty;
    logic back_lt;
    logic front_match;
    logic out_free;
  } stat_t;

endpackage

// ===== hw/rtl/fwm_ctrl.sv =====
// Controller of the running-max FIFO: one-hot state machine that sequences
// each item. Depends on fwm_pkg.
module fwm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  fwm_pkg::stat_t stat,
  output fwm_pkg::cmd_t  cmd
);

  fwm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fwm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == fwm_pkg::S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.status = fwm_pkg::STATUS_OK;
    state_next = state;
    unique case (state)
      fwm_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.op_deq) begin
            if (stat.empty) begin
              cmd.status = fwm_pkg::STATUS_UNDERFLOW;
              state_next = fwm_pkg::S_FIN;
            end else begin
              state_next = fwm_pkg::S_DEQ_POP;
            end
          end else begin
            if (stat.full) begin
              cmd.status = fwm_pkg::STATUS_OVERFLOW;
              state_next = fwm_pkg::S_FIN;
            end else begin
              cmd.entry_push = 1'b1;
              state_next     = fwm_pkg::S_ENQ_SCAN;
            end
          end
        end
      end
      fwm_pkg::S_ENQ_SCAN: begin
        // One smaller candidate leaves the back per cycle.
        if (stat.back_lt) begin
          cmd.cand_drop_back = 1'b1;
        end else begin
          cmd.cand_append = 1'b1;
          state_next      = fwm_pkg::S_FIN;
        end
      end
      fwm_pkg::S_DEQ_POP: begin
        cmd.entry_pop = 1'b1;
        if (stat.front_match) begin
          cmd.cand_drop_front = 1'b1;
          state_next          = fwm_pkg::S_DEQ_MAX;
        end else begin
          state_next = fwm_pkg::S_FIN;
        end
      end
      fwm_pkg::S_DEQ_MAX: begin
        cmd.load_max = 1'b1;
        state_next   = fwm_pkg::S_FIN;
      end
      fwm_pkg::S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = fwm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fwm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/fwm_dp.sv =====
// Datapath of the running-max FIFO: entry and candidate memories, their
// pointers and counts, the current maximum and the output register. Depends on fwm_pkg.
module fwm_dp #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 op,
  input  logic signed [31:0]   value,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic signed [31:0]   out_value,
  output logic signed [31:0]   max_value,
  output logic                 max_valid,
  output logic [1:0]           status,
  output logic [CW-1:0]        fill_level,
  input  fwm_pkg::cmd_t        cmd,
  output fwm_pkg::stat_t       stat
);

  localparam int SW = CW + 1;

  logic signed [31:0] entry_mem [DEPTH];
  logic signed [31:0] cand_mem  [DEPTH];
  logic signed [31:0] entry_rd, cand_rd;

  logic [AW-1:0] ehead, chead;
  logic [CW-1:0] ecnt, ccnt;
  logic          out_valid_q;

  logic signed [31:0] val_r, out_value_r, max_reg;
  fwm_pkg::status_t   status_r;

  logic [AW-1:0] e_tail, ehead_inc, c_tail, chead_inc, c_back, c_rd_addr;
  logic [CW-1:0] c_keep;
  logic          held;

  function automatic logic [AW-1:0] wrap_addr(input logic [SW-1:0] s);
    if (s >= SW'(DEPTH)) begin
      return AW'(s - SW'(DEPTH));
    end
    return AW'(s);
  endfunction

  always_comb begin
    e_tail    = wrap_addr(SW'(ehead) + SW'(ecnt));
    ehead_inc = wrap_addr(SW'(ehead) + SW'(1));
    c_tail    = wrap_addr(SW'(chead) + SW'(ccnt));
    chead_inc = wrap_addr(SW'(chead) + SW'(1));
    // Back of the candidates left after this cycle; meaningless when none remain.
    c_keep    = cmd.cand_drop_back ? ccnt - CW'(1) : ccnt;
    c_back    = wrap_addr(SW'(chead) + SW'(c_keep) - SW'(1));
    c_rd_addr = cmd.cand_drop_front ? chead_inc : c_back;
  end

  always_ff @(posedge clk) begin
    if (cmd.entry_push) begin
      entry_mem[e_tail] <= value;
    end
    entry_rd <= entry_mem[ehead];
  end

  always_ff @(posedge clk) begin
    if (cmd.cand_append) begin
      cand_mem[c_tail] <= val_r;
    end
    cand_rd <= cand_mem[c_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ehead       <= '0;
      ecnt        <= '0;
      chead       <= '0;
      ccnt        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd.entry_push) begin
        ecnt <= ecnt + CW'(1);
      end
      if (cmd.entry_pop) begin
        ehead <= ehead_inc;
        ecnt  <= ecnt - CW'(1);
      end
      if (cmd.cand_drop_back) begin
        ccnt <= ccnt - CW'(1);
      end
      if (cmd.cand_append) begin
        ccnt <= ccnt + CW'(1);
      end
      if (cmd.cand_drop_front) begin
        chead <= chead_inc;
        ccnt  <= ccnt - CW'(1);
      end
      if (cmd.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r       <= value;
      status_r    <= cmd.status;
      out_value_r <= '0;
    end
    if (cmd.entry_pop) begin
      out_value_r <= entry_rd;
    end
    if (cmd.cand_append && ccnt == '0) begin
      max_reg <= val_r;
    end
    if (cmd.load_max) begin
      max_reg <= cand_rd;
    end
  end

  assign held = (ecnt != '0) && (ccnt != '0);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value  <= out_value_r;
      max_value  <= held ? max_reg : 32'sd0;
      max_valid  <= held;
      status     <= status_r;
      fill_level <= ecnt;
    end
  end

  assign out_valid = out_valid_q;

  always_comb begin
    stat.op_deq      = op;
    stat.full        = (ecnt == CW'(DEPTH));
    stat.empty       = (ecnt == '0);
    stat.back_lt     = (ccnt != '0) && (cand_rd < val_r);
    stat.front_match = (ccnt != '0) && (max_reg == entry_rd);
    stat.out_free    = !out_valid_q || out_ready;
  end

endmodule

// ===== hw/rtl/fifo_with_running_max_top.sv =====
// Top level of the FIFO with running maximum: joins controller and datapath.
// Depends on fwm_pkg, fwm_ctrl and fwm_dp.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_ready   op, value
//   output   out_valid / out_ready out_value, max_value, max_valid, status,
//                                  fill_level
//
// An item is taken only while the controller is idle. An enqueue writes the
// entry, drops each smaller candidate from the back of the deque, then appends
// the value; a dequeue pops the entry and, when the front candidate leaves,
// reads the new maximum back. A rejected item (underflow or overflow) goes to
// the final state, where a result not yet taken holds the controller. Reset
// clears pointers, counts and output valid; the memories are not cleared.
module fifo_with_running_max_top #(
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              op,
  input  logic signed [31:0]                value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                out_value,
  output logic signed [31:0]                max_value,
  output logic                              max_valid,
  output logic [1:0]                        status,
  output logic [$clog2(DEPTH + 1)-1:0]      fill_level
);

  // Commands flow from controller to datapath; status flows back.
  fwm_pkg::cmd_t  cmd;
  fwm_pkg::stat_t stat;

  fwm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fwm_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .value      (value),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_value  (out_value),
    .max_value  (max_value),
    .max_valid  (max_valid),
    .status     (status),
    .fill_level (fill_level),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// ===== hw/rtl/fwm_checker.sv =====
// Port-level checker of the running-max FIFO and its bind to the top level.
// Depends on fwm_pkg and fifo_with_running_max_top_defines.svh.
`include "fifo_with_running_max_top_defines.svh"

module fwm_checker #(
  parameter int DEPTH = 64
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [31:0]           out_value,
  input logic                         max_valid,
  input logic [1:0]                   status,
  input logic [$clog2(DEPTH + 1)-1:0] fill_level
);

  // An overflow is reported only when the queue is full.
  `FWM_ASSERT_NOW(a_overflow_full, out_valid && status == fwm_pkg::STATUS_OVERFLOW, fill_level == ($clog2(DEPTH + 1))'(DEPTH))

  // An underflow leaves an empty queue and returns no value.
  `FWM_ASSERT_NOW(a_underflow_empty, out_valid && status == fwm_pkg::STATUS_UNDERFLOW, fill_level == '0 && !max_valid && out_value == 32'sd0)

  // A maximum exists exactly when entries are held.
  `FWM_ASSERT_NOW(a_max_tracks_fill, out_valid, max_valid == (fill_level != '0))

  // A result not taken stays in place.
  `FWM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value))

endmodule

bind fifo_with_running_max_top fwm_checker #(.DEPTH(DEPTH)) u_fwm_checker (.*);
